/* rtl/lcg_prng_jump_ahead_defines.svh */
// ----------------------------------------------------------------------------
// lcg_prng_jump_ahead assertion macros
// shared property wrappers clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef LCG_PRNG_JUMP_AHEAD_DEFINES_SVH
`define LCG_PRNG_JUMP_AHEAD_DEFINES_SVH

// same-cycle implication
`define LCGJA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define LCGJA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/lcgja_pkg.sv */
// ----------------------------------------------------------------------------
// lcgja_pkg
// types, command codes and jump-ahead tables for the lcg generator
// ----------------------------------------------------------------------------
package lcgja_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned RAND_W  = 16;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t word_tab_t [COUNT_W];

  typedef enum logic [ACT_W-1:0] {
    ACT_STEP    = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_LOAD    = 2'd2
  } action_e;

  // one-step multiplier and addend
  localparam word_t LCG_MUL = 32'h41c6_4e61;
  localparam word_t LCG_ADD = 32'h0000_6073;

  // operands of the shared multiply-add
  typedef struct packed {
    word_t seed;
    word_t mul;
    word_t add;
  } mac_op_t;

  // 2^k-step multiplier: m' = m*m
  function automatic word_tab_t gen_mul_tab();
    word_tab_t t;
    word_t     m;
    m = LCG_MUL;
    for (int k = 0; k < COUNT_W; k++) begin
      t[k] = m;
      m    = m * m;
    end
    return t;
  endfunction

  // 2^k-step addend: a' = a*(m+1)
  function automatic word_tab_t gen_add_tab();
    word_tab_t t;
    word_t     m;
    word_t     a;
    m = LCG_MUL;
    a = LCG_ADD;
    for (int k = 0; k < COUNT_W; k++) begin
      t[k] = a;
      a    = a * (m + 32'd1);
      m    = m * m;
    end
    return t;
  endfunction

  localparam word_tab_t JUMP_MUL = gen_mul_tab();
  localparam word_tab_t JUMP_ADD = gen_add_tab();

endpackage

/* rtl/lcgja_mac.sv */
// ----------------------------------------------------------------------------
// lcgja_mac
// shared 32-bit multiply-add, seed*mul + add modulo 2^32
// ----------------------------------------------------------------------------
module lcgja_mac (
  input  lcgja_pkg::mac_op_t op_i,
  output lcgja_pkg::word_t   res_o
);
  import lcgja_pkg::*;

  word_t prod;

  assign prod  = op_i.seed * op_i.mul;
  assign res_o = prod + op_i.add;

endmodule

/* rtl/lcg_prng_jump_ahead.sv */
// ----------------------------------------------------------------------------
// lcg_prng_jump_ahead
// 32-bit lcg seed with single step, load and logarithmic jump-ahead
// sequence: load and unused action go straight from idle to done; step and
//   advance run one multiply-add per count bit up to the highest set bit
// commands: none is taken while busy_o is high, the next command can be taken in
//   the done cycle; busy_o high while the multiply-add loops
// done_o strobes for one cycle with the new seed; the receiver cannot stall
// reset: seed clears to zero, sequencer returns to idle
// ----------------------------------------------------------------------------
`include "lcg_prng_jump_ahead_defines.svh"

module lcg_prng_jump_ahead (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command beat
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [lcgja_pkg::ACT_W-1:0]       action_i,
  input  logic [lcgja_pkg::COUNT_W-1:0]     step_count_i,
  input  logic [lcgja_pkg::WORD_W-1:0]      seed_value_i,
  // result beat
  output logic                              done_o,
  output logic [lcgja_pkg::RAND_W-1:0]      random_value_o,
  output logic [lcgja_pkg::WORD_W-1:0]      seed_out_o
);
  import lcgja_pkg::*;

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam int unsigned K_W = $clog2(COUNT_W);

  logic                 state_q, state_d;
  word_t                seed_q, seed_d;
  logic [COUNT_W-1:0]   count_q, count_d;   // remaining count bits, lsb is bit k
  logic [K_W-1:0]       k_q, k_d;           // table index of the current bit
  logic                 done_q, done_d;

  logic                 accept;
  logic [COUNT_W-1:0]   count_shr;
  mac_op_t              mac_op;
  word_t                mac_res;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign count_shr = count_q >> 1;

  // one multiply-add per cycle, operands from the 2^k tables
  assign mac_op.seed = seed_q;
  assign mac_op.mul  = JUMP_MUL[k_q];
  assign mac_op.add  = JUMP_ADD[k_q];

  lcgja_mac u_mac (
    .op_i  (mac_op),
    .res_o (mac_res)
  );

  always_comb begin
    state_d = state_q;
    seed_d  = seed_q;
    count_d = count_q;
    k_d     = k_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          k_d = '0;
          case (action_i)
            // a single step is an advance by one
            ACT_STEP: begin
              count_d = COUNT_W'(1);
              state_d = ST_RUN;
            end
            ACT_ADVANCE: begin
              count_d = step_count_i;
              if (step_count_i == '0) begin
                done_d = 1'b1;   // zero count leaves the seed alone
              end else begin
                state_d = ST_RUN;
              end
            end
            ACT_LOAD: begin
              seed_d = seed_value_i;
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;     // unused code reports the current seed
            end
          endcase
        end
      end
      ST_RUN: begin
        if (count_q[0]) begin
          seed_d = mac_res;
        end
        count_d = count_shr;
        k_d     = k_q + K_W'(1);
        // stop after the highest set bit
        if (count_shr == '0) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seed_q  <= '0;
      count_q <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
      count_q <= count_d;
      k_q     <= k_d;
      done_q  <= done_d;
    end
  end

  assign busy_o         = (state_q == ST_RUN);
  assign done_o         = done_q;
  assign seed_out_o     = seed_q;
  assign random_value_o = seed_q[WORD_W-1 -: RAND_W];

  // no result beat while the loop is still running
  `LCGJA_ASSERT_IMPL(a_no_done_busy, busy_o, !done_o)
  // loop only runs with count bits left
  `LCGJA_ASSERT_IMPL(a_run_count, state_q == ST_RUN, count_q != '0)
  // load reports the loaded seed in the next cycle
  `LCGJA_ASSERT_NEXT(a_load_done, accept && (action_i == ACT_LOAD),
                     done_o && (seed_out_o == $past(seed_value_i)))
  // seed holds while idle with no command
  `LCGJA_ASSERT_NEXT(a_idle_hold, !busy_o && !start_i, $stable(seed_q))

endmodule
